// ===== src/lesf_pkg.sv =====
// Package for the largest empty square finder: sizes, word types and
// configuration register indexes. No dependencies.
package lesf_pkg;

  // Map limits
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  // Derived widths
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int SCORE_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH     = 2'd0,
    CFG_OBSTACLE_CHAR = 2'd1
  } cfg_idx_t;

  // Input word: one map cell
  typedef struct packed {
    logic [7:0] cell_char;
    logic       map_end;
  } in_word_t;

  // Result word: one per map
  typedef struct packed {
    logic [10:0] square_size;
    logic [9:0]  square_col;
    logic [9:0]  square_row;
    logic        too_tall;
  } out_word_t;

endpackage

// ===== src/largest_empty_square_finder.sv =====
// Largest empty square finder top level: raster cell scoring with a line
// buffer and best-square tracking. Depends on lesf_pkg.
//
// Usage:
//   in_*  : one map cell per word, raster order, map_end set on the last cell.
//   out_* : one result word per map (size, top-left column/row, too_tall).
//   cfg_* : register writes (row width, obstacle character), always ready;
//           write only while the block is idle.
// Throughput: one cell per cycle unless a map-end cell is held (see Stall).
// The line buffer is a 1024 x 11 memory with one write and one registered read
// per cycle; a read that hits the column being written in the same cycle is
// forwarded. Result path: the last cell is registered into the scoring stage,
// then the result word into the output register once that stage advances.
// Reset: counters, scores and the best square clear at once; the line buffer
// is not cleared and needs none, each row overwrites it before it is read.
// Stall: a waiting result does not block cells; only the next map-end cell
// holds in the scoring stage, and then in_ready drops, until out_ready.
module largest_empty_square_finder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lesf_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lesf_pkg::out_word_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lesf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lesf_pkg::CFG_DAT_W-1:0] cfg_data
);
  import lesf_pkg::*;

  // Config registers
  logic [SCORE_W-1:0] row_width_r;
  logic [7:0]         obstacle_char_r;

  // Raster position counters (input side)
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ROW_CNT_W-1:0] row_r, row_nxt;

  // Scoring stage
  logic                 s1_valid_r, s1_valid_nxt;
  logic [7:0]           s1_char_r;
  logic                 s1_last_r;
  logic                 s1_skip_r;
  logic [COL_W-1:0]     s1_col_r;
  logic [ROW_CNT_W-1:0] s1_row_r;
  logic [SCORE_W-1:0]   rd_q_r;
  logic                 fwd_hit_r;
  logic [SCORE_W-1:0]   fwd_val_r;

  // Per-map scoring state
  logic [SCORE_W-1:0] left_r, left_nxt;
  logic [SCORE_W-1:0] diag_r, diag_nxt;
  logic [SCORE_W-1:0] best_size_r, best_size_nxt;
  logic [COL_W-1:0]   best_col_r, best_col_nxt;
  logic [9:0]         best_row_r, best_row_nxt;
  logic               ovf_r, ovf_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  // Line buffer
  logic [SCORE_W-1:0] line_mem [MAX_COLS];

  logic                 in_acc;
  logic                 s1_adv;
  logic                 wr_en;
  logic [SCORE_W-1:0]   width_eff;
  logic                 row_done;
  logic                 in_skip;
  logic [SCORE_W-1:0]   top;
  logic [SCORE_W-1:0]   min_v;
  logic [SCORE_W-1:0]   val;
  logic                 better;
  logic [SCORE_W-1:0]   upd_size;
  logic [COL_W-1:0]     upd_col;
  logic [9:0]           upd_row;
  logic                 upd_ovf;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r     <= SCORE_W'(MAX_COLS);
      obstacle_char_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROW_WIDTH:     row_width_r     <= cfg_data;
        CFG_OBSTACLE_CHAR: obstacle_char_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Effective row width and raster position update
  always_comb begin
    if (row_width_r == '0)
      width_eff = SCORE_W'(1);
    else if (row_width_r > SCORE_W'(MAX_COLS))
      width_eff = SCORE_W'(MAX_COLS);
    else
      width_eff = row_width_r;
    row_done = SCORE_W'(col_r) >= (width_eff - SCORE_W'(1));
    in_skip  = row_r >= ROW_CNT_W'(MAX_ROWS);
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (in_acc) begin
      if (in_data.map_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_done) begin
        col_nxt = '0;
        if (!in_skip)
          row_nxt = row_r + ROW_CNT_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // Scoring: line-buffer top with same-cycle forwarding, 3-way min
  always_comb begin
    top   = fwd_hit_r ? fwd_val_r : rd_q_r;
    min_v = top;
    if (left_r < min_v)
      min_v = left_r;
    if (diag_r < min_v)
      min_v = diag_r;
    if (s1_char_r == obstacle_char_r)
      val = '0;
    else if (s1_row_r == '0 || s1_col_r == '0)
      val = SCORE_W'(1);
    else
      val = min_v + SCORE_W'(1);
    better = !s1_skip_r && (val > best_size_r);
    wr_en  = s1_adv && !s1_skip_r;
  end

  // Best square update and per-map restart
  always_comb begin
    upd_size = best_size_r;
    upd_col  = best_col_r;
    upd_row  = best_row_r;
    upd_ovf  = ovf_r || s1_skip_r;
    if (better) begin
      upd_size = val;
      upd_col  = s1_col_r + COL_W'(1) - val[COL_W-1:0];
      upd_row  = s1_row_r[9:0] + 10'd1 - val[9:0];
    end
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    best_size_nxt = best_size_r;
    best_col_nxt  = best_col_r;
    best_row_nxt  = best_row_r;
    ovf_nxt       = ovf_r;
    if (s1_adv) begin
      if (s1_last_r) begin
        left_nxt      = '0;
        diag_nxt      = '0;
        best_size_nxt = '0;
        best_col_nxt  = '0;
        best_row_nxt  = '0;
        ovf_nxt       = 1'b0;
      end else begin
        if (!s1_skip_r) begin
          left_nxt = val;
          diag_nxt = top;
        end
        best_size_nxt = upd_size;
        best_col_nxt  = upd_col;
        best_row_nxt  = upd_row;
        ovf_nxt       = upd_ovf;
      end
    end
  end

  // Stage valid and output valid
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)
      s1_valid_nxt = 1'b1;
    else if (s1_adv)
      s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_last_r)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      diag_r      <= '0;
      best_size_r <= '0;
      best_col_r  <= '0;
      best_row_r  <= '0;
      ovf_r       <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      left_r      <= left_nxt;
      diag_r      <= diag_nxt;
      best_size_r <= best_size_nxt;
      best_col_r  <= best_col_nxt;
      best_row_r  <= best_row_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // Scoring stage payload, loaded on accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_data.cell_char;
      s1_last_r <= in_data.map_end;
      s1_skip_r <= in_skip;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      fwd_hit_r <= wr_en && (s1_col_r == col_r);
      fwd_val_r <= val;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_word_r.square_size <= upd_size;
      out_word_r.square_col  <= upd_col;
      out_word_r.square_row  <= upd_row;
      out_word_r.too_tall    <= upd_ovf;
    end
  end

  // Line buffer: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en)
      line_mem[s1_col_r] <= val;
  end

  always_ff @(posedge clk) begin
    if (in_acc)
      rd_q_r <= line_mem[col_r];
  end

`ifndef NO_ASSERTIONS
  // A map-end cell leaving the scoring stage always lands a result word
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> out_valid_r)
    else $error("map end did not produce a result word");

  // Input only stalls while a cell is held in the scoring stage
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_ready))
    else $error("input stalled without a held map-end cell");

  // Row counter saturates at the row limit
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_CNT_W'(MAX_ROWS))
    else $error("row counter past limit");

  // No square means a zero corner
  a_empty_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (best_size_r == '0) |-> (best_col_r == '0 && best_row_r == '0))
    else $error("corner set without a square");
`endif

endmodule

// ===== test/tb_largest_empty_square_finder.sv =====
`timescale 1ns / 100ps
// Testbench for largest_empty_square_finder: directed table, then random maps,
// checked against a cell-by-cell scoring predictor or typed results; needs lesf_pkg.
module tb_largest_empty_square_finder;
  import lesf_pkg::*;

  // Kinds of rows in the directed table
  typedef enum bit {
    STEP_CELL,
    STEP_REG
  } step_kind_t;

  typedef struct {
    step_kind_t  kind;
    cfg_idx_t    reg_idx;
    logic [10:0] reg_val;
    in_word_t    cell_word;
    bit          typed;
    out_word_t   result;
  } step_t;

  // Receiver stall patterns
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_MOSTLY,
    RX_SPARSE
  } rx_mode_t;

  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_CELLS  = 500;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROW_WIDTH;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  largest_empty_square_finder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Predictor state: register copies plus the scoring state of the block
  logic [10:0] row_width_q = 11'd1024;
  logic [7:0]  obstacle_q  = 8'd0;
  logic [10:0] line_scores [MAX_COLS];
  logic [10:0] left_q, diag_q, best_size_q;
  logic [9:0]  col_q, best_col_q, best_row_q;
  logic [10:0] row_q;
  logic        too_tall_q;

  out_word_t expected_squares [$];
  int        mismatch_count = 0;
  int        burst_left     = 0;
  int        hold_requests  = 0;
  int        holds_served   = 0;
  step_t     script [0:22];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [10:0] got,
                             input logic [10:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic clear_map_state();
    left_q      = '0;
    diag_q      = '0;
    col_q       = '0;
    row_q       = '0;
    best_size_q = '0;
    best_col_q  = '0;
    best_row_q  = '0;
    too_tall_q  = 1'b0;
  endtask

  // Score one cell; on the map's last cell, hand back the best square
  task automatic score_cell(input in_word_t word, output bit emits, output out_word_t res);
    logic [10:0] eff_w, top, val, low;
    bit          row_done;
    eff_w = (row_width_q == 0) ? 11'd1 :
            (row_width_q > MAX_COLS) ? 11'(MAX_COLS) : row_width_q;
    row_done = ({1'b0, col_q} >= eff_w - 11'd1);
    if (row_q >= MAX_ROWS) begin
      too_tall_q = 1'b1;
    end else begin
      top = line_scores[col_q];
      if (word.cell_char == obstacle_q) begin
        val = '0;
      end else if (row_q == 0 || col_q == 0) begin
        val = 11'd1;
      end else begin
        low = top;
        if (left_q < low) low = left_q;
        if (diag_q < low) low = diag_q;
        val = low + 11'd1;
      end
      // strictly larger only: the first square of a size wins
      if (val > best_size_q) begin
        best_size_q = val;
        best_col_q  = 10'({1'b0, col_q} + 11'd1 - val);
        best_row_q  = 10'(row_q + 11'd1 - val);
      end
      diag_q = top;
      left_q = val;
      line_scores[col_q] = val;
    end
    if (row_done) begin
      col_q = '0;
      if (row_q < MAX_ROWS) row_q++;
    end else begin
      col_q++;
    end
    emits = word.map_end;
    res.square_size = best_size_q;
    res.square_col  = best_col_q;
    res.square_row  = best_row_q;
    res.too_tall    = too_tall_q;
    if (emits) clear_map_state();
  endtask

  // Offer one cell in bursts with random gaps, then predict on acceptance
  task automatic send_cell(input in_word_t word, input bit use_typed,
                           input out_word_t typed);
    int        gap;
    bit        emits;
    out_word_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    score_cell(word, emits, predicted);
    if (emits) expected_squares.push_back(use_typed ? typed : predicted);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_squares.size() != 0) @(posedge clk);
  endtask

  // Register write with the block idle and the pipeline settled
  task automatic write_register(input cfg_idx_t idx, input logic [10:0] val);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROW_WIDTH) row_width_q = val;
    else obstacle_q = val[7:0];
  endtask

  // One map of n cells; cells from free_from on are never obstacles
  task automatic send_map(input int n, input int pct, input int free_from, input int mid_at);
    in_word_t  word;
    out_word_t none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      if (i == mid_at) begin
        if ($urandom_range(0, 1) == 0) write_register(CFG_ROW_WIDTH, 11'($urandom_range(1, 12)));
        else write_register(CFG_OBSTACLE_CHAR, 11'($urandom_range(0, 2047)));
      end
      if (i < free_from && $urandom_range(0, 99) < pct) begin
        word.cell_char = obstacle_q;
      end else begin
        do word.cell_char = 8'($urandom); while (word.cell_char == obstacle_q);
      end
      word.map_end = (i == n - 1);
      send_cell(word, 1'b0, none);
    end
  endtask

  function automatic step_t cell_step(input logic [7:0] ch, input bit last);
    step_t s;
    s = '{STEP_CELL, CFG_ROW_WIDTH, 11'd0, '0, 1'b0, '0};
    s.cell_word.cell_char = ch;
    s.cell_word.map_end   = last;
    return s;
  endfunction

  function automatic step_t typed_step(input logic [7:0] ch, input logic [10:0] size,
                                       input logic [9:0] col, input logic [9:0] row);
    step_t s;
    s = cell_step(ch, 1'b1);
    s.typed = 1'b1;
    s.result.square_size = size;
    s.result.square_col  = col;
    s.result.square_row  = row;
    s.result.too_tall    = 1'b0;
    return s;
  endfunction

  function automatic step_t reg_step(input cfg_idx_t idx, input logic [10:0] val);
    step_t s;
    s = '{STEP_REG, idx, val, '0, 1'b0, '0};
    return s;
  endfunction

  // Result checker
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_squares.size() == 0) begin
        report_mismatch("result word with none expected");
      end else begin
        want = expected_squares.pop_front();
        check_field("square_size", out_data.square_size, want.square_size);
        check_field("square_col", 11'(out_data.square_col), 11'(want.square_col));
        check_field("square_row", 11'(out_data.square_row), 11'(want.square_row));
        check_field("too_tall", 11'(out_data.too_tall), 11'(want.too_tall));
      end
    end
  end

  // Receiver: random stall phases, plus a long hold-off on request
  rx_mode_t rx_mode    = RX_OPEN;
  int       phase_left = 0;
  int       hold_left  = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        rx_mode    = rx_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(10, 80);
      end
      phase_left--;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
        default:   out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    #2_000_000;
    $display("largest_empty_square_finder verification failed");
    $finish;
  end

  // Stimulus
  initial begin
    int random_cells, map_no, eff, n_cells, pct, mid_at;
    for (int i = 0; i < MAX_COLS; i++) line_scores[i] = '0;
    clear_map_state();

    // directed table: reset values, extremes, clamped widths, mid-map width change
    script[0]  = typed_step(8'h00, 11'd0, 10'd0, 10'd0);
    script[1]  = typed_step(8'hFF, 11'd1, 10'd0, 10'd0);
    script[2]  = reg_step(CFG_ROW_WIDTH, 11'd2);
    script[3]  = reg_step(CFG_OBSTACLE_CHAR, 11'd255);
    script[4]  = cell_step(8'h00, 1'b0);
    script[5]  = cell_step(8'h00, 1'b0);
    script[6]  = cell_step(8'h00, 1'b0);
    script[7]  = typed_step(8'h00, 11'd2, 10'd0, 10'd0);
    script[8]  = reg_step(CFG_ROW_WIDTH, 11'd0);
    script[9]  = cell_step(8'h61, 1'b0);
    script[10] = cell_step(8'h61, 1'b0);
    script[11] = typed_step(8'h61, 11'd1, 10'd0, 10'd0);
    script[12] = reg_step(CFG_ROW_WIDTH, 11'd2047);
    script[13] = cell_step(8'hFF, 1'b0);
    script[14] = typed_step(8'h01, 11'd1, 10'd1, 10'd0);
    script[15] = reg_step(CFG_ROW_WIDTH, 11'd3);
    script[16] = cell_step(8'h7E, 1'b0);
    script[17] = cell_step(8'h81, 1'b0);
    script[18] = cell_step(8'h42, 1'b0);
    script[19] = cell_step(8'h24, 1'b0);
    script[20] = reg_step(CFG_ROW_WIDTH, 11'd1);
    script[21] = cell_step(8'h18, 1'b0);
    script[22] = cell_step(8'hFF, 1'b1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == STEP_REG) write_register(script[i].reg_idx, script[i].reg_val);
      else send_cell(script[i].cell_word, script[i].typed, script[i].result);
    end

    // full-width row fills the whole line buffer; free cells are its last column and the two after it
    write_register(CFG_ROW_WIDTH, 11'd1024);
    write_register(CFG_OBSTACLE_CHAR, 11'($urandom_range(0, 255)));
    send_map(1026, 100, 1023, -1);
    // one column: exactly the row limit, then past it
    write_register(CFG_ROW_WIDTH, 11'd1);
    send_map(MAX_ROWS, 100, MAX_ROWS - 1, -1);
    send_map(MAX_ROWS + 6, 100, MAX_ROWS - 1, -1);

    // random maps: mostly whole rows, some ending mid-row
    random_cells = 0;
    map_no = 0;
    while (random_cells < RANDOM_CELLS) begin
      if (map_no == 6) begin
        // receiver holds off while short maps pile up behind it
        hold_requests++;
        repeat (10) send_map(2, 50, 2, -1);
        wait_for_results();
        random_cells += 20;
      end
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 9))
          0:       write_register(CFG_ROW_WIDTH, 11'd0);
          1:       write_register(CFG_ROW_WIDTH, 11'd1024);
          2:       write_register(CFG_ROW_WIDTH, 11'd2047);
          3:       write_register(CFG_ROW_WIDTH, 11'($urandom_range(13, 2047)));
          default: write_register(CFG_ROW_WIDTH, 11'($urandom_range(1, 12)));
        endcase
      end
      if ($urandom_range(0, 4) == 0) begin
        write_register(CFG_OBSTACLE_CHAR, 11'($urandom_range(0, 2047)));
      end
      eff = (row_width_q == 0) ? 1 : (row_width_q > MAX_COLS) ? MAX_COLS : int'(row_width_q);
      if (eff <= 12 && $urandom_range(0, 3) != 0) n_cells = eff * int'($urandom_range(1, 6));
      else n_cells = int'($urandom_range(1, 40));
      case ($urandom_range(0, 4))
        0:       pct = 0;
        1:       pct = 10;
        2:       pct = 25;
        3:       pct = 50;
        default: pct = 90;
      endcase
      mid_at = (n_cells > 2 && $urandom_range(0, 9) == 0) ?
               int'($urandom_range(1, n_cells - 1)) : -1;
      send_map(n_cells, pct, n_cells, mid_at);
      random_cells += n_cells;
      map_no++;
    end

    // drain, then keep watching for stray results before the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 5000 && expected_squares.size() != 0; k++) @(posedge clk);
    if (expected_squares.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_squares.size()));
    repeat (SETTLE_CYCLES + 4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("largest_empty_square_finder verification clean");
    end else begin
      $display("largest_empty_square_finder verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lesf_pkg.sv
src/largest_empty_square_finder.sv
test/tb_largest_empty_square_finder.sv
